>>> rtl/bccq_pkg.sv
// ----------------------------------------------------------------------------
// bccq_pkg
// Shared types and constants of the batch completion count queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bccq_pkg;

   // Default sizing of the count queue
   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int DEFAULT_COUNT_BITS  = 15;

   // Fixed field widths
   localparam int ITEM_W      = 16;
   localparam int AMOUNT_W    = ITEM_W - 1;
   localparam int TOTAL_OUT_W = 19;

   // Request kinds
   localparam logic [1:0] REQ_BEGIN   = 2'd0;
   localparam logic [1:0] REQ_CONSUME = 2'd1;
   localparam logic [1:0] REQ_CLEAR   = 2'd2;

   typedef struct packed {
      logic [1:0]               req_type;
      logic signed [ITEM_W-1:0] item_count;
   } bccq_req_type;

   typedef struct packed {
      logic                   ok;
      logic                   full_drop;
      logic                   has_pending;
      logic [TOTAL_OUT_W-1:0] pending_total;
   } bccq_rsp_type;

endpackage

`default_nettype wire

>>> rtl/bccq_ram.sv
// ----------------------------------------------------------------------------
// bccq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bccq_ram #(
   parameter int WIDTH = bccq_pkg::DEFAULT_COUNT_BITS,
   parameter int DEPTH = bccq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/bccq_rsp_buffer.sv
// ----------------------------------------------------------------------------
// bccq_rsp_buffer
// Output register with one skid entry for result transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module bccq_rsp_buffer (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire bccq_pkg::bccq_rsp_type in_data,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output bccq_pkg::bccq_rsp_type      out_data
);

   import bccq_pkg::*;

   logic         out_valid_ff;
   logic         out_valid_in;
   bccq_rsp_type out_data_ff;
   bccq_rsp_type out_data_in;
   logic         hold_valid_ff;
   logic         hold_valid_in;
   bccq_rsp_type hold_data_ff;
   bccq_rsp_type hold_data_in;
   logic         push;
   logic         out_free;

   assign in_ready = !hold_valid_ff;
   assign push     = in_valid && in_ready;
   assign out_free = !out_valid_ff || out_ready;

   // Load the output from the skid entry or a new result, or park the new result
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      hold_valid_in = hold_valid_ff;
      hold_data_in  = hold_data_ff;
      if (out_free) begin
         if (hold_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = hold_data_ff;
            hold_valid_in = 1'b0;
         end else if (push) begin
            out_valid_in = 1'b1;
            out_data_in  = in_data;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         hold_valid_in = 1'b1;
         hold_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      hold_data_ff <= hold_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

`default_nettype wire

>>> rtl/batch_completion_count_queue_unit.sv
// Results: begin, clear and rejected requests pass their result on transfer
//   to the registered response buffer; a consume first walks the head batches
//   it visits, one count memory read each, and then passes its result on.
// Throughput: one begin or clear per cycle while the response buffer has room; a
//   consume walk blocks new requests. A second result may wait in the skid entry.
// Reset: synchronous; empties the queue and the pending total, not the count memory.
// ----------------------------------------------------------------------------
// batch_completion_count_queue_unit
// FIFO of per-batch outstanding counts kept in a synchronous RAM; consumes
// walk the head batches one per cycle with read-modify-write.
// ----------------------------------------------------------------------------
`default_nettype none

module batch_completion_count_queue_unit #(
   parameter int QUEUE_DEPTH = bccq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int COUNT_BITS  = bccq_pkg::DEFAULT_COUNT_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire bccq_pkg::bccq_req_type req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output bccq_pkg::bccq_rsp_type      rsp_payload
);

   import bccq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam int TOT_W = COUNT_BITS + OCC_W;

   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [OCC_W-1:0] OCC_FULL  = OCC_W'(QUEUE_DEPTH);
   localparam logic [31:0]      COUNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);
   localparam logic [63:0]      TOTAL_SAT = 64'((65'd1 << TOTAL_OUT_W) - 65'd1);

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_WALK = 1'b1;

   logic                  state_ff;
   logic                  state_in;
   logic [IDX_W-1:0]      head_ff;
   logic [IDX_W-1:0]      head_in;
   logic [IDX_W-1:0]      tail_ff;
   logic [IDX_W-1:0]      tail_in;
   logic [OCC_W-1:0]      occ_ff;
   logic [OCC_W-1:0]      occ_in;
   logic [TOT_W-1:0]      total_ff;
   logic [TOT_W-1:0]      total_in;
   logic [AMOUNT_W-1:0]   left_ff;
   logic [AMOUNT_W-1:0]   left_in;

   logic                  req_accept;
   logic                  positive;
   logic [AMOUNT_W-1:0]   amount;
   logic [31:0]           amount_sat;
   logic [COUNT_BITS-1:0] begin_count;
   logic [IDX_W-1:0]      head_nx;
   logic [IDX_W-1:0]      tail_nx;

   logic [COUNT_BITS-1:0] ram_rd_data;
   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   logic [COUNT_BITS-1:0] ram_wdata;
   logic                  ram_re;
   logic [IDX_W-1:0]      ram_raddr;

   logic [31:0]           cur_ext;
   logic [31:0]           left_ext;
   logic [31:0]           take;
   logic [COUNT_BITS-1:0] new_cur;
   logic [AMOUNT_W-1:0]   new_left;
   logic [63:0]           total_ext;

   logic                  buf_in_valid;
   logic                  buf_in_ready;
   bccq_rsp_type          result;

   // Decode the request
   assign req_ready   = (state_ff == STATE_IDLE) && buf_in_ready;
   assign req_accept  = req_valid && req_ready;
   assign positive    = (req_payload.item_count != '0) && !req_payload.item_count[ITEM_W-1];
   assign amount      = req_payload.item_count[AMOUNT_W-1:0];
   assign amount_sat  = (32'(amount) > COUNT_MAX) ? COUNT_MAX : 32'(amount);
   assign begin_count = amount_sat[COUNT_BITS-1:0];

   // Ring index wrap
   assign head_nx = (head_ff == IDX_LAST) ? '0 : head_ff + IDX_W'(1);
   assign tail_nx = (tail_ff == IDX_LAST) ? '0 : tail_ff + IDX_W'(1);

   // Retire from the head batch read in the previous cycle
   assign cur_ext  = 32'(ram_rd_data);
   assign left_ext = 32'(left_ff);
   assign take     = (cur_ext < left_ext) ? cur_ext : left_ext;
   assign new_cur  = ram_rd_data - COUNT_BITS'(take);
   assign new_left = left_ff - AMOUNT_W'(take);

   // Queue control and result build
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      total_in     = total_ff;
      left_in      = left_ff;
      ram_we       = 1'b0;
      ram_waddr    = tail_ff;
      ram_wdata    = begin_count;
      ram_re       = 1'b0;
      ram_raddr    = head_ff;
      buf_in_valid = 1'b0;
      result       = '0;
      unique case (state_ff)
         STATE_IDLE: begin
            if (req_accept) begin
               unique case (req_payload.req_type)
                  REQ_BEGIN: begin
                     buf_in_valid = 1'b1;
                     if (positive) begin
                        if (occ_ff == OCC_FULL) begin
                           result.full_drop = 1'b1;
                        end else begin
                           result.ok = (occ_ff == '0);
                           ram_we    = 1'b1;
                           tail_in   = tail_nx;
                           occ_in    = occ_ff + OCC_W'(1);
                           total_in  = total_ff + TOT_W'(begin_count);
                        end
                     end
                  end
                  REQ_CONSUME: begin
                     if (positive && (occ_ff != '0)) begin
                        state_in = STATE_WALK;
                        left_in  = amount;
                        ram_re   = 1'b1;
                     end else begin
                        buf_in_valid = 1'b1;
                     end
                  end
                  REQ_CLEAR: begin
                     buf_in_valid = 1'b1;
                     result.ok    = 1'b1;
                     head_in      = '0;
                     tail_in      = '0;
                     occ_in       = '0;
                     total_in     = '0;
                  end
                  default: begin
                     buf_in_valid = 1'b1;
                  end
               endcase
            end
         end
         STATE_WALK: begin
            total_in = total_ff - TOT_W'(take);
            if (new_cur == '0) begin
               // drop the emptied head batch
               head_in = head_nx;
               occ_in  = occ_ff - OCC_W'(1);
            end else begin
               ram_we    = 1'b1;
               ram_waddr = head_ff;
               ram_wdata = new_cur;
            end
            if ((new_left != '0) && (occ_in != '0)) begin
               ram_re    = 1'b1;
               ram_raddr = head_in;
               left_in   = new_left;
            end else begin
               state_in     = STATE_IDLE;
               buf_in_valid = 1'b1;
               result.ok    = 1'b1;
               if (occ_in == '0) begin
                  head_in  = '0;
                  tail_in  = '0;
                  total_in = '0;
               end
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
      result.has_pending   = (occ_in != '0);
      result.pending_total = (64'(total_in) > TOTAL_SAT) ? '1 : TOTAL_OUT_W'(total_in);
   end

   assign total_ext = 64'(total_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         occ_ff   <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         occ_ff   <= occ_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
   end

   bccq_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rd_data)
   );

   bccq_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (buf_in_valid),
      .in_ready  (buf_in_ready),
      .in_data   (result),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_payload)
   );

   // Occupancy stays within the ring
   assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_FULL)
      else $error("count queue occupancy beyond depth");

   // An empty queue holds no pending items
   assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0) |-> (total_ext == 64'd0))
      else $error("pending total nonzero on empty queue");

   // A walk only runs over a non-empty queue with items left to retire
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_WALK) |-> ((occ_ff != '0) && (left_ff != '0)))
      else $error("consume walk on empty queue");

   // A finished result always finds room in the response buffer
   assert property (@(posedge clock) disable iff (reset)
      buf_in_valid |-> buf_in_ready)
      else $error("result lost at response buffer");

endmodule

`default_nettype wire
